>>> src/thresholded_call_concordance_table_assert.svh
// Assertion macros used by the concordance table RTL.
`ifndef THRESHOLDED_CALL_CONCORDANCE_TABLE_ASSERT_SVH
`define THRESHOLDED_CALL_CONCORDANCE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> src/tcct_pkg.sv
// Package with item types and constants of the call concordance table.
`timescale 1ns / 1ps
`default_nettype none
package tcct_pkg;

	localparam int PROB_W = 16;
	localparam int CALL_W = 2;
	localparam int CELL_COUNT_W = 20;
	localparam int TABLE_SIDE = 4;
	localparam int TABLE_CELLS = TABLE_SIDE * TABLE_SIDE;
	localparam int CELL_IDX_W = $clog2(TABLE_CELLS);

	localparam logic [CALL_W-1:0] MISSING_CALL = 2'd3;
	localparam logic [PROB_W-1:0] CALL_THRESHOLD_RESET = 16'd58982;

	// Operation codes carried in the op field.
	localparam logic OP_TALLY = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic op;
		logic [PROB_W-1:0] left_prob_0;
		logic [PROB_W-1:0] left_prob_1;
		logic [PROB_W-1:0] left_prob_2;
		logic [PROB_W-1:0] right_prob_0;
		logic [PROB_W-1:0] right_prob_1;
		logic [PROB_W-1:0] right_prob_2;
	} sample_t;

	typedef struct packed {
		logic [CALL_W-1:0] left_call;
		logic [CALL_W-1:0] right_call;
		logic [CELL_COUNT_W-1:0] cell_count;
		logic last;
	} result_t;

endpackage
`default_nettype wire

>>> src/tcct_call_pick.sv
// Genotype call of one side: argmax of three probabilities with a threshold.
`timescale 1ns / 1ps
`default_nettype none
module tcct_call_pick (
	input  wire logic [tcct_pkg::PROB_W-1:0] prob_0,
	input  wire logic [tcct_pkg::PROB_W-1:0] prob_1,
	input  wire logic [tcct_pkg::PROB_W-1:0] prob_2,
	input  wire logic [tcct_pkg::PROB_W-1:0] threshold,
	output logic [tcct_pkg::CALL_W-1:0] call
);
	import tcct_pkg::*;

	logic [PROB_W-1:0] best_01;
	logic [CALL_W-1:0] idx_01;
	logic [PROB_W-1:0] best;
	logic [CALL_W-1:0] idx;

	// First stage of the argmax; the lower index wins a tie.
	always_comb begin
		if (prob_1 > prob_0) begin
			best_01 = prob_1;
			idx_01 = 2'd1;
		end else begin
			best_01 = prob_0;
			idx_01 = 2'd0;
		end
	end

	// Second stage of the argmax, again keeping the lower index on a tie.
	always_comb begin
		if (prob_2 > best_01) begin
			best = prob_2;
			idx = 2'd2;
		end else begin
			best = best_01;
			idx = idx_01;
		end
	end

	// A best probability under the threshold makes the call missing.
	assign call = (best < threshold) ? MISSING_CALL : idx;

endmodule
`default_nettype wire

>>> src/thresholded_call_concordance_table.sv
// Top level of the thresholded call concordance table.
//
// Usage:
// An item is accepted at a rising edge with start high and busy low. A tally
// item (op = 0) classifies the left and right probability sets and bumps one
// saturating counter of the 4x4 table; while busy is low, tallies are taken
// one per cycle and counted on the edge after acceptance. A finish item
// (op = 1) snapshots the table into an unload shift line and clears the table
// in the same edge. The 16 cells then leave in row-major order, one per cycle,
// each marked by result_valid for exactly one cycle; the first goes through
// the input, drain and result registers, and the sixteenth carries last. Busy
// stays high from the cycle after a finish is accepted until the last cell is
// out. The unload shift line and the one-entry input register set this rate.
// The receiver cannot stall: every strobed result is taken.
// Reset clears the table, the pipeline and the unload control, and loads the
// threshold with its default of about 0.9. cfg_we writes cfg_data into the
// threshold; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module thresholded_call_concordance_table #(
	parameter int COUNT_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire tcct_pkg::sample_t sample,
	input  wire logic cfg_we,
	input  wire logic [tcct_pkg::PROB_W-1:0] cfg_data,
	output logic result_valid,
	output tcct_pkg::result_t result
);
	import tcct_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(TABLE_CELLS - 1);

	logic [PROB_W-1:0] threshold_q;
	logic valid_s1;
	sample_t sample_s1;
	logic [CALL_W-1:0] left_call;
	logic [CALL_W-1:0] right_call;
	logic [CELL_IDX_W-1:0] hit_idx;
	logic tally_s1;
	logic finish_s1;
	logic [COUNT_BITS-1:0] count_q [TABLE_CELLS];
	logic [COUNT_BITS-1:0] unload_q [TABLE_CELLS];
	logic drain_q;
	logic [CELL_IDX_W-1:0] drain_idx_q;
	logic accept;

	assign accept = start && !busy;
	assign busy = (valid_s1 && finish_s1) || drain_q;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= CALL_THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	// Calls of the two sides.
	tcct_call_pick u_left_pick (
		.prob_0    (sample_s1.left_prob_0),
		.prob_1    (sample_s1.left_prob_1),
		.prob_2    (sample_s1.left_prob_2),
		.threshold (threshold_q),
		.call      (left_call)
	);

	tcct_call_pick u_right_pick (
		.prob_0    (sample_s1.right_prob_0),
		.prob_1    (sample_s1.right_prob_1),
		.prob_2    (sample_s1.right_prob_2),
		.threshold (threshold_q),
		.call      (right_call)
	);

	assign hit_idx = {left_call, right_call};
	assign tally_s1 = valid_s1 && (sample_s1.op == OP_TALLY);
	assign finish_s1 = (sample_s1.op == OP_FINISH);

	// Table counters: each one bumps itself when its cell is hit, saturating; all clear on a finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_CELLS; k++) begin
				count_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < TABLE_CELLS; k++) begin
				priority if (valid_s1 && finish_s1) begin
					count_q[k] <= '0;
				end else if (tally_s1 && (hit_idx == CELL_IDX_W'(k))
						&& (count_q[k] != COUNT_MAX)) begin
					count_q[k] <= count_q[k] + 1'b1;
				end else begin
					count_q[k] <= count_q[k];
				end
			end
		end
	end

	// Unload shift line: loaded from the table on finish, shifted while draining.
	always_ff @(posedge clk) begin
		if (valid_s1 && finish_s1) begin
			for (int k = 0; k < TABLE_CELLS; k++) begin
				unload_q[k] <= count_q[k];
			end
		end else if (drain_q) begin
			for (int k = 0; k < TABLE_CELLS - 1; k++) begin
				unload_q[k] <= unload_q[k + 1];
			end
		end
	end

	// Drain control: walks the 16 cells in row-major order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			drain_idx_q <= '0;
		end else if (valid_s1 && finish_s1) begin
			drain_q <= 1'b1;
			drain_idx_q <= '0;
		end else if (drain_q) begin
			drain_idx_q <= drain_idx_q + 1'b1;
			if (drain_idx_q == LAST_CELL) begin
				drain_q <= 1'b0;
			end
		end
	end

	// Result register: one cell per cycle while draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= drain_q;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q) begin
			result.left_call <= drain_idx_q[CELL_IDX_W-1:CALL_W];
			result.right_call <= drain_idx_q[CALL_W-1:0];
			result.cell_count <= CELL_COUNT_W'(unload_q[0]);
			result.last <= (drain_idx_q == LAST_CELL);
		end
	end

`include "thresholded_call_concordance_table_assert.svh"

	`TCCT_ASSERT_NEXT(a_drain_strobes, clk, arst_n, drain_q, result_valid)
	`TCCT_ASSERT_NEXT(a_finish_busy, clk, arst_n, accept && (sample.op == OP_FINISH), busy)
	`TCCT_ASSERT_NEXT(a_last_ends_burst, clk, arst_n, result_valid && result.last, !result_valid)
	`TCCT_ASSERT_IMP(a_last_cell, clk, arst_n, result_valid && result.last,
		(result.left_call == MISSING_CALL) && (result.right_call == MISSING_CALL))

endmodule
`default_nettype wire
